// File: src/assert_macros.svh
// Assertion macros used by the pick unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: src/rasp_pkg.sv
// Shared constants and types of the axis shaft pick unit.
package rasp_pkg;
	localparam logic [30:0] RadiusReset = 31'd6554;
	localparam logic [64:0] ParallelLimit = 65'd4295;
	localparam logic signed [65:0] SLow = -66'sd13107;
	localparam logic signed [65:0] SHigh = 66'sd78643;
	localparam logic [1:0] AxisX = 2'd0;
	localparam logic [1:0] AxisY = 2'd1;
	localparam logic [1:0] AxisZ = 2'd2;
	localparam logic [1:0] AxisNone = 2'd3;
	// Number of quotient bits developed: 15 integer and 16 fraction, plus overflow bit.
	localparam int unsigned QuotBits = 32;

	// Per-item data that rides along the divider.
	typedef struct packed {
		logic               live;
		logic [1:0]         ax;
		logic signed [31:0] wa;
		logic signed [31:0] wp;
		logic signed [31:0] wq;
		logic signed [31:0] da;
		logic signed [31:0] dp;
		logic signed [31:0] dq;
		logic signed [31:0] na;
		logic signed [31:0] np;
		logic signed [31:0] nq;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// File: src/rasp_front.sv
// Front stages: offsets, axis swizzle, denominator and numerator products.
module rasp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [31:0]    ox, oy, oz, dx, dy, dz, nx, ny, nz,
	input  logic [1:0]            axis,
	output logic                  out_valid,
	output rasp_pkg::side_t       side,
	output logic [64:0]           den,
	output logic [63:0]           mag
);
	logic                 v_s1, v_s2;
	rasp_pkg::side_t      sd_s1, sd_s2;
	logic signed [63:0]   dpp_s2, dqq_s2, pp_s2, pq_s2;

	// Stage 1: offsets and axis reordering.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		logic signed [31:0] wx, wy, wz;
		wx = rasp_pkg::sat32(66'(ox) - 66'(nx));
		wy = rasp_pkg::sat32(66'(oy) - 66'(ny));
		wz = rasp_pkg::sat32(66'(oz) - 66'(nz));
		sd_s1.live <= (axis != rasp_pkg::AxisNone);
		sd_s1.ax <= axis;
		case (axis)
			rasp_pkg::AxisY: begin
				sd_s1.wa <= wy; sd_s1.wp <= wz; sd_s1.wq <= wx;
				sd_s1.da <= dy; sd_s1.dp <= dz; sd_s1.dq <= dx;
				sd_s1.na <= ny; sd_s1.np <= nz; sd_s1.nq <= nx;
			end
			rasp_pkg::AxisZ: begin
				sd_s1.wa <= wz; sd_s1.wp <= wx; sd_s1.wq <= wy;
				sd_s1.da <= dz; sd_s1.dp <= dx; sd_s1.dq <= dy;
				sd_s1.na <= nz; sd_s1.np <= nx; sd_s1.nq <= ny;
			end
			default: begin
				sd_s1.wa <= wx; sd_s1.wp <= wy; sd_s1.wq <= wz;
				sd_s1.da <= dx; sd_s1.dp <= dy; sd_s1.dq <= dz;
				sd_s1.na <= nx; sd_s1.np <= ny; sd_s1.nq <= nz;
			end
		endcase
	end

	// Stage 2: four 32x32 products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		sd_s2 <= sd_s1;
		dpp_s2 <= sd_s1.dp * sd_s1.dp;
		dqq_s2 <= sd_s1.dq * sd_s1.dq;
		pp_s2 <= sd_s1.dp * sd_s1.wp;
		pq_s2 <= sd_s1.dq * sd_s1.wq;
	end

	// Stage 3: sums and early miss tests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= v_s2;
	end
	always_ff @(posedge clk) begin
		logic [64:0] d;
		logic signed [64:0] n;
		rasp_pkg::side_t sd;
		d = {1'b0, dpp_s2} + {1'b0, dqq_s2};
		n = 65'(pp_s2) + 65'(pq_s2);
		sd = sd_s2;
		sd.live = sd_s2.live && (d >= rasp_pkg::ParallelLimit) && (n <= 65'sd0);
		side <= sd;
		den <= d;
		mag <= 64'(-n);
	end
endmodule

// File: src/rasp_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module rasp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rasp_pkg::side_t   in_side,
	input  logic [64:0]       den,
	input  logic [63:0]       mag,
	output logic              out_valid,
	output rasp_pkg::side_t   out_side,
	output logic [30:0]       t
);
	localparam int unsigned N = rasp_pkg::QuotBits;

	logic [N:0]             v;
	rasp_pkg::side_t        sd [N+1];
	logic [64:0]            dn [N+1];
	logic [79:0]            rm [N+1];
	logic [N-1:0]           qt [N+1];

	assign v[0] = in_valid;
	assign sd[0] = in_side;
	assign dn[0] = den;
	assign rm[0] = {mag, 16'd0};
	assign qt[0] = '0;

	// Each stage tests one shifted divisor against the remainder.
	for (genvar i = 0; i < N; i++) begin : g_st
		localparam int unsigned Sh = N - 1 - i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v[i+1] <= 1'b0;
			else v[i+1] <= v[i];
		end
		always_ff @(posedge clk) begin
			logic [111:0] sub;
			sub = 112'(dn[i]) << Sh;
			sd[i+1] <= sd[i];
			dn[i+1] <= dn[i];
			if (112'(rm[i]) >= sub) begin
				rm[i+1] <= 80'(112'(rm[i]) - sub);
				qt[i+1] <= qt[i] | (N'(1) << Sh);
			end else begin
				rm[i+1] <= rm[i];
				qt[i+1] <= qt[i];
			end
		end
	end

	assign out_valid = v[N];
	assign out_side = sd[N];
	assign t = qt[N][N-1] ? 31'h7fffffff : qt[N][30:0];
endmodule

// File: src/rasp_back.sv
// Back stages: closest points, range tests and the squared gap compare.
module rasp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rasp_pkg::side_t   side,
	input  logic [30:0]       t,
	input  logic [30:0]       radius,
	output logic              strobe,
	output logic              hit,
	output logic [30:0]       ray_param,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);
	logic v_s1, v_s2, v_s3;
	rasp_pkg::side_t sd_s1, sd_s2;
	logic [30:0] t_s1, t_s2, t_s3;
	logic signed [63:0] ma_s1, mp_s1, mq_s1, g2p_s3, g2q_s3;
	logic signed [65:0] s_s2;
	logic signed [31:0] gp_s2, gq_s2, pa_s3;
	logic ok_s3;
	logic [1:0] ax_s3;
	logic signed [31:0] np_s3, nq_s3;
	logic [61:0] r2_s3;

	// Stage 1: the three t products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; strobe <= 1'b0; end
		else begin v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; strobe <= v_s3; end
	end
	always_ff @(posedge clk) begin
		sd_s1 <= side;
		t_s1 <= t;
		ma_s1 <= side.da * $signed({1'b0, t});
		mp_s1 <= side.dp * $signed({1'b0, t});
		mq_s1 <= side.dq * $signed({1'b0, t});
	end

	// Stage 2: axis parameter and gap components (arithmetic shift is floor).
	always_ff @(posedge clk) begin
		logic signed [65:0] s;
		s = 66'(sd_s1.wa) + 66'(ma_s1 >>> 16);
		sd_s2 <= sd_s1;
		t_s2 <= t_s1;
		s_s2 <= s;
		gp_s2 <= rasp_pkg::sat32(66'(sd_s1.wp) + 66'(mp_s1 >>> 16));
		gq_s2 <= rasp_pkg::sat32(66'(sd_s1.wq) + 66'(mq_s1 >>> 16));
	end

	// Stage 3: squares, range test and point on the axis.
	always_ff @(posedge clk) begin
		ok_s3 <= sd_s2.live && (s_s2 >= rasp_pkg::SLow) && (s_s2 <= rasp_pkg::SHigh);
		g2p_s3 <= gp_s2 * gp_s2;
		g2q_s3 <= gq_s2 * gq_s2;
		r2_s3 <= radius * radius;
		pa_s3 <= rasp_pkg::sat32(66'(sd_s2.na) + s_s2);
		np_s3 <= sd_s2.np;
		nq_s3 <= sd_s2.nq;
		ax_s3 <= sd_s2.ax;
		t_s3 <= t_s2;
	end

	// Stage 4: final decision; misses give zeros.
	always_ff @(posedge clk) begin
		logic h;
		logic [64:0] sq;
		logic signed [31:0] px, py, pz;
		sq = {1'b0, 64'(g2p_s3)} + {1'b0, 64'(g2q_s3)};
		h = ok_s3 && (sq < 65'(r2_s3));
		px = '0;
		py = '0;
		pz = '0;
		if (h) begin
			case (ax_s3)
				rasp_pkg::AxisY: begin px = nq_s3; py = pa_s3; pz = np_s3; end
				rasp_pkg::AxisZ: begin px = np_s3; py = nq_s3; pz = pa_s3; end
				default: begin px = pa_s3; py = np_s3; pz = nq_s3; end
			endcase
		end
		hit <= h;
		ray_param <= h ? t_s3 : '0;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
	end
endmodule

// File: src/ray_axis_shaft_pick_unit.sv
// Top level of the ray to axis shaft pick unit.
//  channel  | handshake            | payload
//  query    | start / busy         | ray_origin_*, ray_dir_*, node_*, axis_select
//  config   | cfg_valid / cfg_ready| cfg_data (hit_radius)
//  result   | done strobe          | hit, ray_param, point_*
// One query is accepted per cycle; busy is always low.
// The pipeline has three front stages, 32 divider stages and four back stages.
// The 32-stage restoring divider for t sets the depth.
// Reset clears valid bits and sets hit_radius to its reset value.
// The receiver cannot stall; results leave on done for one cycle.
`include "assert_macros.svh"
module ray_axis_shaft_pick_unit #(
	parameter logic [30:0] RadiusInit = rasp_pkg::RadiusReset
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] ray_origin_x, ray_origin_y, ray_origin_z,
	input  logic signed [31:0] ray_dir_x, ray_dir_y, ray_dir_z,
	input  logic signed [31:0] node_x, node_y, node_z,
	input  logic [1:0]         axis_select,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data,
	output logic               done,
	output logic               hit,
	output logic [30:0]        ray_param,
	output logic signed [31:0] point_x, point_y, point_z
);
	logic [30:0] radius_q;
	logic fv, dv;
	rasp_pkg::side_t fs, ds;
	logic [64:0] den;
	logic [63:0] mag;
	logic [30:0] t;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= RadiusInit;
		else if (cfg_valid && cfg_ready) radius_q <= cfg_data;
	end

	rasp_front u_front (.clk, .arst_n, .in_valid(start && !busy),
		.ox(ray_origin_x), .oy(ray_origin_y), .oz(ray_origin_z),
		.dx(ray_dir_x), .dy(ray_dir_y), .dz(ray_dir_z),
		.nx(node_x), .ny(node_y), .nz(node_z), .axis(axis_select),
		.out_valid(fv), .side(fs), .den, .mag);
	rasp_div u_div (.clk, .arst_n, .in_valid(fv), .in_side(fs), .den, .mag,
		.out_valid(dv), .out_side(ds), .t);
	rasp_back u_back (.clk, .arst_n, .in_valid(dv), .side(ds), .t, .radius(radius_q),
		.strobe(done), .hit, .ray_param, .point_x, .point_y, .point_z);

	`ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !hit, ray_param == '0, "miss with nonzero t")
	`ASSERT_IMPL(a_miss_pt, clk, arst_n, done && !hit, {point_x, point_y, point_z} == '0, "miss point")
	`ASSERT_NEXT(a_cfg, clk, arst_n, cfg_valid, radius_q == $past(cfg_data), "radius write")
endmodule
